[rtl/core/assert_macros.svh]
// Assertion macros shared by the allocator RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, switched off while rst is high.
`define SCP_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Checked on every rising edge of clk, reset included.
`define SCP_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

[rtl/core/scp_pkg.sv]
// Shared constants, types and the size class table of the pool allocator.
// No dependencies; imported by size_class_pool_allocator_unit.
package scp_pkg;

   localparam int DEF_POOL_GRANULES = 65536;
   localparam int DEF_HEADER_BYTES  = 16;
   localparam int DEF_NUM_CLASSES   = 9;

   localparam int TABLE_CLASSES = 9;
   localparam int CLS_W         = 4;    // class number, one code past the last means none
   localparam int SIZE_W        = 24;   // request size and class size
   localparam int OFS_W         = 21;   // data offsets
   localparam int TOT_W         = 22;   // running total and bump pointer
   localparam int CAP_W         = 22;   // capacity register
   localparam int GRANULE_SHIFT = 5;    // 32-byte granules

   localparam logic [CAP_W-1:0] CAP_RESET = 22'd2097152;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 48;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef enum logic {
      SCP_IDLE,
      SCP_EXEC
   } scp_state_type;

   function automatic logic [SIZE_W-1:0] class_bytes(input logic [CLS_W-1:0] idx);
      logic [SIZE_W-1:0] sz;
      case (idx)
         4'd0:    sz = 24'd32;
         4'd1:    sz = 24'd128;
         4'd2:    sz = 24'd512;
         4'd3:    sz = 24'd1024;
         4'd4:    sz = 24'd2048;
         4'd5:    sz = 24'd8192;
         4'd6:    sz = 24'd1048576;
         4'd7:    sz = 24'd4194304;
         4'd8:    sz = 24'd8388608;
         default: sz = 24'd8388608;
      endcase
      return sz;
   endfunction

endpackage

[rtl/core/size_class_pool_allocator_unit.sv]
// Segregated free list pool allocator with one header memory and head registers.
// Depends on scp_pkg and assert_macros.svh.
`include "assert_macros.svh"

// In the accept cycle of a request word the header memory is read (the head
// block of the chosen free list on allocate, the freed block on free); in
// the next cycle a header entry is written (the read one, or a new one at
// the bump pointer; none on a refusal) with the list heads, bump pointer
// and running total, and the response word is loaded into the output
// register. The single-port header memory with its registered read is what
// splits each word into these steps. A new request is taken while the
// previous response is handed over, but not while the block is busy with
// the last word. Free list heads live in flip-flops with valid bits cleared
// by reset; the header memory needs no clearing pass.
module size_class_pool_allocator_unit #(
   parameter int POOL_GRANULES = scp_pkg::DEF_POOL_GRANULES,
   parameter int HEADER_BYTES  = scp_pkg::DEF_HEADER_BYTES,
   parameter int NUM_CLASSES   = scp_pkg::DEF_NUM_CLASSES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [23:0] request_bytes, [44:24] data_offset, [47:45] zero
   input  logic [scp_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [0] action
   input  logic [0:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [20:0] block_offset, [42:21] allocated_total, [47:43] zero
   output logic [scp_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // [0] granted
   output logic [0:0]                       rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [scp_pkg::CAP_W-1:0]        csr_data
);
   import scp_pkg::*;

   localparam int GRAN_W      = $clog2(POOL_GRANULES);
   localparam int CLASS_COUNT = (NUM_CLASSES < TABLE_CLASSES) ? NUM_CLASSES : TABLE_CLASSES;
   localparam int RAW_W       = OFS_W - GRANULE_SHIFT;
   localparam int P_LOG       = $clog2(POOL_GRANULES + 1) - 1;
   localparam int MOD_STEPS   = (POOL_GRANULES >= (1 << RAW_W)) ? 0 : RAW_W - P_LOG;
   localparam logic [25:0] POOL_LIMIT = 26'(POOL_GRANULES * 32);

   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic [GRAN_W-1:0] link;
      logic              link_valid;
   } hdr_type;

   // Smallest class that holds total; CLASS_COUNT when none does.
   function automatic logic [CLS_W-1:0] pick_class(input logic [SIZE_W:0] total);
      logic [CLS_W-1:0] c;
      c = '0;
      for (int i = 0; i < CLASS_COUNT; i++) begin
         if (total > {1'b0, class_bytes(CLS_W'(i))}) c = c + CLS_W'(1);
      end
      return c;
   endfunction

   // Granule number modulo the pool size, by restoring subtraction of the
   // shifted pool size; the quotient never has more than MOD_STEPS bits.
   function automatic logic [GRAN_W-1:0] wrap_gran(input logic [RAW_W-1:0] raw);
      logic [31:0] rem;
      rem = 32'(raw);
      for (int k = MOD_STEPS - 1; k >= 0; k--) begin
         if (rem >= (32'(POOL_GRANULES) << k)) rem = rem - (32'(POOL_GRANULES) << k);
      end
      return rem[GRAN_W-1:0];
   endfunction

   hdr_type hdr_mem [POOL_GRANULES];
   hdr_type rd_data_ff;

   scp_state_type state_ff, state_in;

   logic [CAP_W-1:0]  pool_cap_ff;
   logic [TOT_W-1:0]  bump_next_ff, bump_next_in;
   logic [TOT_W-1:0]  used_ff, used_in;
   logic [GRAN_W-1:0] head_idx_ff [CLASS_COUNT];
   logic [GRAN_W-1:0] head_idx_in [CLASS_COUNT];
   logic [CLASS_COUNT-1:0] head_vld_ff, head_vld_in;

   logic              act_ff, act_in;
   logic [SIZE_W-1:0] req_ff, req_in;
   logic [CLS_W-1:0]  class_ff, class_in;
   logic [GRAN_W-1:0] gran_ff, gran_in;
   logic              hit_ff, hit_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_granted_ff, rsp_granted_in;
   logic [OFS_W-1:0]  rsp_offset_ff, rsp_offset_in;
   logic [TOT_W-1:0]  rsp_total_ff, rsp_total_in;

   logic              req_accept;
   logic [SIZE_W-1:0] in_request;
   logic [OFS_W-1:0]  in_offset;
   logic [OFS_W-1:0]  free_start;
   logic [GRAN_W-1:0] free_gran;
   logic [CLS_W-1:0]  alloc_class;
   logic [GRAN_W-1:0] head_sel_idx;
   logic              head_sel_vld;

   logic [SIZE_W-1:0] alloc_sz;
   logic [CLS_W-1:0]  free_class_raw, free_class;
   logic [SIZE_W-1:0] free_sz;
   logic [25:0]       cap_eff, bump_sum;
   logic              cap_ok;
   logic [31:0]       bump_gran_wide, reuse_ofs_wide;
   logic              exec_refuse;

   logic              mem_wr_en;
   logic [GRAN_W-1:0] mem_wr_addr;
   hdr_type           mem_wr_data;

   // Neither channel takes a word while reset is held.
   assign req_accept = req_tvalid && req_tready;
   assign req_tready = !reset && (state_ff == SCP_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = !reset;

   assign in_request = req_tdata[SIZE_W-1:0];
   assign in_offset  = req_tdata[SIZE_W+OFS_W-1:SIZE_W];
   assign free_start = in_offset - OFS_W'(HEADER_BYTES);
   assign free_gran  = wrap_gran(free_start[OFS_W-1:GRANULE_SHIFT]);
   assign alloc_class = pick_class({1'b0, in_request} + (SIZE_W + 1)'(HEADER_BYTES));

   always_comb begin
      head_sel_idx = '0;
      head_sel_vld = 1'b0;
      for (int i = 0; i < CLASS_COUNT; i++) begin
         if (alloc_class == CLS_W'(i)) begin
            head_sel_idx = head_idx_ff[i];
            head_sel_vld = head_vld_ff[i];
         end
      end
   end

   // Work of the execute state, all from registered item and read data.
   assign alloc_sz       = class_bytes(class_ff);
   assign free_class_raw = pick_class({1'b0, rd_data_ff.size} + (SIZE_W + 1)'(HEADER_BYTES));
   assign free_class     = (free_class_raw >= CLS_W'(CLASS_COUNT)) ?
                           CLS_W'(CLASS_COUNT - 1) : free_class_raw;
   assign free_sz        = class_bytes(free_class);
   assign cap_eff        = ({4'b0, pool_cap_ff} > POOL_LIMIT) ? POOL_LIMIT : {4'b0, pool_cap_ff};
   assign bump_sum       = {4'b0, bump_next_ff} + {2'b0, alloc_sz};
   assign cap_ok         = cap_eff >= bump_sum;
   assign bump_gran_wide = 32'(bump_next_ff >> GRANULE_SHIFT);
   assign reuse_ofs_wide = (32'(gran_ff) << GRANULE_SHIFT) + 32'(HEADER_BYTES);
   assign exec_refuse    = (state_ff == SCP_EXEC) && (act_ff == ACT_ALLOC) &&
                           ((class_ff >= CLS_W'(CLASS_COUNT)) || (!hit_ff && !cap_ok));

   always_comb begin
      state_in       = state_ff;
      bump_next_in   = bump_next_ff;
      used_in        = used_ff;
      head_idx_in    = head_idx_ff;
      head_vld_in    = head_vld_ff;
      act_in         = act_ff;
      req_in         = req_ff;
      class_in       = class_ff;
      gran_in        = gran_ff;
      hit_in         = hit_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_granted_in = rsp_granted_ff;
      rsp_offset_in  = rsp_offset_ff;
      rsp_total_in   = rsp_total_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = gran_ff;
      mem_wr_data    = rd_data_ff;

      case (state_ff)
         SCP_IDLE: begin
            if (req_accept) begin
               state_in = SCP_EXEC;
               act_in   = req_tuser[0];
               req_in   = in_request;
               class_in = alloc_class;
               hit_in   = head_sel_vld;
               gran_in  = (req_tuser[0] == ACT_FREE) ? free_gran : head_sel_idx;
            end
         end
         SCP_EXEC: begin
            state_in       = SCP_IDLE;
            rsp_valid_in   = 1'b1;
            rsp_granted_in = 1'b0;
            rsp_offset_in  = '0;
            if (act_ff == ACT_FREE) begin
               // Push the block; its header keeps the stored size.
               used_in                 = used_ff - TOT_W'(free_sz);
               mem_wr_en               = 1'b1;
               mem_wr_data.size        = rd_data_ff.size;
               mem_wr_data.link        = '0;
               mem_wr_data.link_valid  = 1'b0;
               for (int i = 0; i < CLASS_COUNT; i++) begin
                  if (free_class == CLS_W'(i)) begin
                     mem_wr_data.link       = head_idx_ff[i];
                     mem_wr_data.link_valid = head_vld_ff[i];
                     head_idx_in[i]         = gran_ff;
                     head_vld_in[i]         = 1'b1;
                  end
               end
               rsp_granted_in = 1'b1;
            end else if (class_ff < CLS_W'(CLASS_COUNT)) begin
               if (hit_ff) begin
                  // Pop the head; the reused block keeps its old stored size.
                  for (int i = 0; i < CLASS_COUNT; i++) begin
                     if (class_ff == CLS_W'(i)) begin
                        head_idx_in[i] = rd_data_ff.link;
                        head_vld_in[i] = rd_data_ff.link_valid;
                     end
                  end
                  mem_wr_en              = 1'b1;
                  mem_wr_data.size       = rd_data_ff.size;
                  mem_wr_data.link       = '0;
                  mem_wr_data.link_valid = 1'b0;
                  used_in                = used_ff + TOT_W'(alloc_sz);
                  rsp_granted_in         = 1'b1;
                  rsp_offset_in          = reuse_ofs_wide[OFS_W-1:0];
               end else if (cap_ok) begin
                  mem_wr_en              = 1'b1;
                  mem_wr_addr            = bump_gran_wide[GRAN_W-1:0];
                  mem_wr_data.size       = req_ff;
                  mem_wr_data.link       = '0;
                  mem_wr_data.link_valid = 1'b0;
                  rsp_offset_in          = OFS_W'(bump_next_ff + TOT_W'(HEADER_BYTES));
                  bump_next_in           = bump_sum[TOT_W-1:0];
                  used_in                = used_ff + TOT_W'(alloc_sz);
                  rsp_granted_in         = 1'b1;
               end
            end
            rsp_total_in = used_in;
         end
         default: begin
            state_in = SCP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SCP_IDLE;
         pool_cap_ff  <= CAP_RESET;
         bump_next_ff <= '0;
         used_ff      <= '0;
         head_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bump_next_ff <= bump_next_in;
         used_ff      <= used_in;
         head_vld_ff  <= head_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            pool_cap_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      head_idx_ff    <= head_idx_in;
      act_ff         <= act_in;
      req_ff         <= req_in;
      class_ff       <= class_in;
      gran_ff        <= gran_in;
      hit_ff         <= hit_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_offset_ff  <= rsp_offset_in;
      rsp_total_ff   <= rsp_total_in;
   end

   // Header memory: one read in the accept cycle, one write in the next.
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         hdr_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (req_accept) begin
         rd_data_ff <= hdr_mem[gran_in];
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_granted_ff;
   assign rsp_tdata    = {(RSP_TDATA_W - OFS_W - TOT_W)'(0), rsp_total_ff, rsp_offset_ff};

   // The output register is always free when a result is produced.
   `SCP_ASSERT(a_slot_free, clock, reset, req_accept |=> !rsp_valid_ff, "result slot busy after accept")
   // Every execute step is followed by a valid response word.
   `SCP_ASSERT(a_result_due, clock, reset, (state_ff == SCP_EXEC) |=> rsp_valid_ff, "missing response")
   // A refused allocation changes neither the bump pointer nor the total.
   `SCP_ASSERT(a_refuse_quiet, clock, reset, exec_refuse |=> ($stable(bump_next_ff) && $stable(used_ff)), "refusal changed state")
   // A refused allocation reports offset zero.
   `SCP_ASSERT(a_refuse_offset, clock, reset, exec_refuse |=> (rsp_offset_ff == '0 && !rsp_granted_ff), "refusal with offset")

endmodule
